[hdl/torus_point_zbuffer_shader_top_macros.svh]
// Assertion macros for the torus point shader blocks.
// Used by the controller; no other dependencies.
`ifndef TORUS_POINT_ZBUFFER_SHADER_TOP_MACROS_SVH
`define TORUS_POINT_ZBUFFER_SHADER_TOP_MACROS_SVH
`ifndef SYNTH
`define TPZ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tpz assertion failed");
`define TPZ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tpz sequence assertion failed");
`else
`define TPZ_ASSERT(lbl, clk, rstn, prop)
`define TPZ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/tpz_pkg.sv]
// Shared types, constants and microcode for the torus point shader.
// No dependencies.
`default_nettype none
package tpz_pkg;

    localparam int SCREEN_WIDTH   = 32;
    localparam int SCREEN_HEIGHT  = 32;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int CELLS          = 1024;
    localparam int CELL_W         = 10;
    localparam int SHADE_MAX      = 11;
    localparam int WW             = 26;       // working word
    localparam int PW             = 2 * WW;   // product
    localparam int XW             = 60;       // projection accumulator
    localparam int PROJ_SHIFT     = 39;
    localparam int OOZ_SHIFT      = 27;       // 1/z = 2^27 / z
    localparam int QW             = OOZ_SHIFT + 1;
    localparam int DVW            = 25;       // divisor width
    localparam int CW             = 22;       // screen coordinate width
    localparam int PCW            = 6;

    typedef logic signed [WW-1:0] t_word;
    localparam t_word ONE_Q = t_word'(1) <<< TRIG_FRAC_BITS;

    localparam logic [PCW-1:0] PC_Z_LAST = PCW'(26);
    localparam logic [PCW-1:0] PC_PROJ   = PCW'(27);
    localparam logic [PCW-1:0] PC_LAST   = PCW'(33);

    localparam logic [6:0] CHAR_SPACE = 7'd32;

    typedef enum logic [1:0] {
        CMD_PLOT  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_FACE   = 3'd1,
        ST_HIDDEN = 3'd2,
        ST_OFF    = 3'd3,
        ST_ZNEG   = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] cos_tube_angle;
        logic signed [15:0] sin_tube_angle;
        logic signed [15:0] cos_ring_angle;
        logic signed [15:0] sin_ring_angle;
        logic [9:0]         read_cell;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] cell_index;
        logic [6:0] shade_char;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] cos_rot_a;
        logic signed [15:0] sin_rot_a;
        logic signed [15:0] cos_rot_b;
        logic signed [15:0] sin_rot_b;
        logic [15:0]        tube_radius;
        logic [15:0]        ring_radius;
        logic [15:0]        viewer_distance;
        logic [15:0]        projection_scale;
    } t_cfg;

    typedef enum logic [4:0] {
        SRC_CT, SRC_ST, SRC_CP, SRC_SP,
        SRC_CA, SRC_SA, SRC_CB, SRC_SB,
        SRC_R1, SRC_R2, SRC_K2, SRC_K1,
        SRC_ONE, SRC_OOZ, SRC_KZH, SRC_KZL,
        SRC_CX, SRC_CY, SRC_SASB, SRC_SACB,
        SRC_MX, SRC_MY, SRC_X, SRC_Y,
        SRC_T1, SRC_T2
    } t_src;

    typedef enum logic [3:0] {
        D_CX, D_CY, D_SASB, D_SACB, D_MX, D_MY,
        D_X, D_Y, D_Z, D_T1, D_T2, D_LUM
    } t_dst;

    typedef enum logic [2:0] {
        OP_SETQ, OP_ADDQ, OP_SUBQ, OP_KZ,
        OP_PHI, OP_PLO, OP_FINX, OP_FINY
    } t_op;

    typedef struct packed {
        t_op  op;
        t_src a_sel;
        t_src b_sel;
        t_dst dst;
    } t_ucmd;

    typedef struct packed {
        logic    accept;
        logic    issue;
        logic    wb;
        t_ucmd   uc;
        logic    div_start;
        logic    lat_cell;
        logic    clr_wr;
        logic    out_load;
        t_status out_status;
        logic    draw;
    } t_cmd;

    typedef struct packed {
        logic       z_nonpos;
        logic       off_screen;
        logic       lum_neg;
        logic       hidden;
        logic       div_done;
        logic       clr_last;
        logic       out_free;
        logic [1:0] cmd;
    } t_stat;

    function automatic t_ucmd tpz_ucode(input logic [PCW-1:0] pc);
        t_ucmd u;
        u = '{OP_SETQ, SRC_ONE, SRC_ONE, D_T1};
        case (pc)
            6'd0:  u = '{OP_SETQ, SRC_R2,   SRC_ONE, D_CX};
            6'd1:  u = '{OP_ADDQ, SRC_R1,   SRC_CT,  D_CX};
            6'd2:  u = '{OP_SETQ, SRC_R1,   SRC_ST,  D_CY};
            6'd3:  u = '{OP_SETQ, SRC_SA,   SRC_SB,  D_SASB};
            6'd4:  u = '{OP_SETQ, SRC_SA,   SRC_CB,  D_SACB};
            6'd5:  u = '{OP_SETQ, SRC_CB,   SRC_CP,  D_MX};
            6'd6:  u = '{OP_ADDQ, SRC_SASB, SRC_SP,  D_MX};
            6'd7:  u = '{OP_SETQ, SRC_SB,   SRC_CP,  D_MY};
            6'd8:  u = '{OP_SUBQ, SRC_SACB, SRC_SP,  D_MY};
            6'd9:  u = '{OP_SETQ, SRC_CY,   SRC_CA,  D_T1};
            6'd10: u = '{OP_SETQ, SRC_CX,   SRC_MX,  D_X};
            6'd11: u = '{OP_SUBQ, SRC_T1,   SRC_SB,  D_X};
            6'd12: u = '{OP_SETQ, SRC_CX,   SRC_MY,  D_Y};
            6'd13: u = '{OP_ADDQ, SRC_T1,   SRC_CB,  D_Y};
            6'd14: u = '{OP_SETQ, SRC_CA,   SRC_CX,  D_T2};
            6'd15: u = '{OP_SETQ, SRC_K2,   SRC_ONE, D_Z};
            6'd16: u = '{OP_ADDQ, SRC_T2,   SRC_SP,  D_Z};
            6'd17: u = '{OP_ADDQ, SRC_CY,   SRC_SA,  D_Z};
            6'd18: u = '{OP_SETQ, SRC_CP,   SRC_CT,  D_T1};
            6'd19: u = '{OP_SETQ, SRC_T1,   SRC_SB,  D_LUM};
            6'd20: u = '{OP_SETQ, SRC_CA,   SRC_CT,  D_T2};
            6'd21: u = '{OP_SUBQ, SRC_T2,   SRC_SP,  D_LUM};
            6'd22: u = '{OP_SUBQ, SRC_SA,   SRC_ST,  D_LUM};
            6'd23: u = '{OP_SETQ, SRC_CA,   SRC_ST,  D_T1};
            6'd24: u = '{OP_SETQ, SRC_CT,   SRC_SA,  D_T2};
            6'd25: u = '{OP_SUBQ, SRC_T2,   SRC_SP,  D_T1};
            6'd26: u = '{OP_ADDQ, SRC_CB,   SRC_T1,  D_LUM};
            6'd27: u = '{OP_KZ,   SRC_K1,   SRC_OOZ, D_T1};
            6'd28: u = '{OP_PHI,  SRC_KZH,  SRC_X,   D_T1};
            6'd29: u = '{OP_PLO,  SRC_KZL,  SRC_X,   D_T1};
            6'd30: u = '{OP_FINX, SRC_ONE,  SRC_ONE, D_T1};
            6'd31: u = '{OP_PHI,  SRC_KZH,  SRC_Y,   D_T1};
            6'd32: u = '{OP_PLO,  SRC_KZL,  SRC_Y,   D_T1};
            6'd33: u = '{OP_FINY, SRC_ONE,  SRC_ONE, D_T1};
            default: ;
        endcase
        return u;
    endfunction

    function automatic logic [6:0] tpz_shade(input logic [3:0] idx);
        logic [6:0] c;
        case (idx)
            4'd0:    c = 7'd46;   // .
            4'd1:    c = 7'd44;   // ,
            4'd2:    c = 7'd45;   // -
            4'd3:    c = 7'd126;  // ~
            4'd4:    c = 7'd58;   // :
            4'd5:    c = 7'd59;   // ;
            4'd6:    c = 7'd61;   // =
            4'd7:    c = 7'd33;   // !
            4'd8:    c = 7'd42;   // *
            4'd9:    c = 7'd35;   // #
            4'd10:   c = 7'd36;   // $
            default: c = 7'd64;   // @
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[hdl/torus_point_zbuffer_shader_top.sv]
// Torus point shader top level: APB register file, controller and datapath.
// Depends on tpz_pkg, tpz_ctrl and tpz_dp.
//
// Plots rotated, projected torus surface points into a 32x32 depth-tested
// character frame. A plot beat runs a decode, 27 multiply steps on one
// shared multiplier, each an issue and a write-back, a z check, the
// 28-step restoring divider for 1/z, seven projection steps, then range
// check, depth store read, compare and output load. A read beat goes from
// decode straight to output load, and a clear beat sweeps the 1024 cells
// of both stores at one cell a cycle.
// After reset the same sweep runs with input stalled; register writes are
// taken throughout. One item is worked on at a time, but the next one is
// accepted while a result waits in the output register.
`default_nettype none
module torus_point_zbuffer_shader_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire tpz_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output tpz_pkg::t_out_item      o_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import tpz_pkg::*;

    localparam logic [2:0] REG_COS_A = 3'd0;
    localparam logic [2:0] REG_SIN_A = 3'd1;
    localparam logic [2:0] REG_COS_B = 3'd2;
    localparam logic [2:0] REG_SIN_B = 3'd3;
    localparam logic [2:0] REG_TUBE  = 3'd4;
    localparam logic [2:0] REG_RING  = 3'd5;
    localparam logic [2:0] REG_DIST  = 3'd6;
    localparam logic [2:0] REG_SCALE = 3'd7;

    t_cfg        r_cfg;
    t_cmd        cmd;
    t_stat       stat;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_rot_a        <= 16'sd16384;
            r_cfg.sin_rot_a        <= 16'sd0;
            r_cfg.cos_rot_b        <= 16'sd16384;
            r_cfg.sin_rot_b        <= 16'sd0;
            r_cfg.tube_radius      <= 16'd4096;
            r_cfg.ring_radius      <= 16'd8192;
            r_cfg.viewer_distance  <= 16'd16384;
            r_cfg.projection_scale <= 16'd43691;
        end else if (wr_en) begin
            case (reg_idx)
                REG_COS_A: r_cfg.cos_rot_a        <= pwdata[15:0];
                REG_SIN_A: r_cfg.sin_rot_a        <= pwdata[15:0];
                REG_COS_B: r_cfg.cos_rot_b        <= pwdata[15:0];
                REG_SIN_B: r_cfg.sin_rot_b        <= pwdata[15:0];
                REG_TUBE:  r_cfg.tube_radius      <= pwdata[15:0];
                REG_RING:  r_cfg.ring_radius      <= pwdata[15:0];
                REG_DIST:  r_cfg.viewer_distance  <= pwdata[15:0];
                REG_SCALE: r_cfg.projection_scale <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COS_A: prdata = {16'b0, r_cfg.cos_rot_a};
            REG_SIN_A: prdata = {16'b0, r_cfg.sin_rot_a};
            REG_COS_B: prdata = {16'b0, r_cfg.cos_rot_b};
            REG_SIN_B: prdata = {16'b0, r_cfg.sin_rot_b};
            REG_TUBE:  prdata = {16'b0, r_cfg.tube_radius};
            REG_RING:  prdata = {16'b0, r_cfg.ring_radius};
            REG_DIST:  prdata = {16'b0, r_cfg.viewer_distance};
            REG_SCALE: prdata = {16'b0, r_cfg.projection_scale};
            default:   prdata = '0;
        endcase
    end

    tpz_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    tpz_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_out_stall (i_stall),
        .o_stat      (stat),
        .o_out_valid (o_valid),
        .o_out       (o_item)
    );

endmodule
`default_nettype wire

[hdl/tpz_div.sv]
// Restoring divider for 2^27 / z, one quotient bit per cycle.
// Depends on tpz_pkg.
`default_nettype none
module tpz_div (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [tpz_pkg::DVW-1:0] i_divisor,
    output logic                        o_busy,
    output logic [tpz_pkg::QW-1:0]      o_quot
);
    import tpz_pkg::*;

    localparam int CNW = $clog2(QW);

    logic            r_busy;
    logic [CNW-1:0]  r_cnt;
    logic [DVW-1:0]  r_rem;
    logic [QW-1:0]   r_quot;
    logic [DVW:0]    rem_sh;
    logic            ge;
    logic [DVW-1:0]  n_rem;

    // dividend is a single set bit at OOZ_SHIFT
    assign rem_sh = {r_rem, (r_cnt == CNW'(OOZ_SHIFT))};
    assign ge     = rem_sh >= (DVW+1)'(i_divisor);
    assign n_rem  = ge ? DVW'(rem_sh - (DVW+1)'(i_divisor)) : DVW'(rem_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNW'(QW - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

[hdl/tpz_dp.sv]
// Datapath: shared multiplier, temporaries, divider, depth and character stores.
// Depends on tpz_pkg and tpz_div.
`default_nettype none
module tpz_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tpz_pkg::t_in_item  i_item,
    input  wire tpz_pkg::t_cfg      i_cfg,
    input  wire tpz_pkg::t_cmd      i_cmd,
    input  wire logic               i_out_stall,
    output tpz_pkg::t_stat          o_stat,
    output logic                    o_out_valid,
    output tpz_pkg::t_out_item      o_out
);
    import tpz_pkg::*;

    localparam logic signed [PW-1:0] Q_BIAS = (PW'(1) <<< TRIG_FRAC_BITS) - PW'(1);
    localparam logic signed [XW-1:0] P_BIAS = (XW'(1) <<< PROJ_SHIFT) - XW'(1);
    localparam int AW = 9;

    t_in_item              r_item;
    t_word                 r_cx, r_cy, r_sasb, r_sacb, r_mx, r_my;
    t_word                 r_x, r_y, r_z, r_t1, r_t2, r_lum;
    logic signed [PW-1:0]  r_prod;
    logic [31:0]           r_kz;
    logic signed [XW-1:0]  r_wide;
    logic signed [CW-1:0]  r_xp, r_yp;
    logic [CELL_W-1:0]     r_cell;
    logic [CELL_W-1:0]     r_clr_cnt;
    logic [15:0]           r_depth_mem [CELLS];
    logic [6:0]            r_char_mem [CELLS];
    logic [15:0]           r_rd_depth;
    logic [6:0]            r_rd_char;
    logic                  r_ovalid;
    t_out_item             r_out;

    t_word                 op_a, op_b, q;
    logic signed [PW-1:0]  q_adj;
    logic signed [XW-1:0]  w_adj;
    logic signed [CW-1:0]  proj_off;
    logic                  div_busy;
    logic [QW-1:0]         div_quot;
    logic [15:0]           ooz;
    logic [16:0]           cell_full;
    logic                  out_range;
    logic [CELL_W-1:0]     rd_addr;
    t_word                 li_raw;
    logic [3:0]            li;
    logic [6:0]            new_char;
    logic                  out_free;

    function automatic t_word sel_src(input t_src s);
        t_word v;
        case (s)
            SRC_CT:   v = WW'(r_item.cos_tube_angle);
            SRC_ST:   v = WW'(r_item.sin_tube_angle);
            SRC_CP:   v = WW'(r_item.cos_ring_angle);
            SRC_SP:   v = WW'(r_item.sin_ring_angle);
            SRC_CA:   v = WW'(i_cfg.cos_rot_a);
            SRC_SA:   v = WW'(i_cfg.sin_rot_a);
            SRC_CB:   v = WW'(i_cfg.cos_rot_b);
            SRC_SB:   v = WW'(i_cfg.sin_rot_b);
            SRC_R1:   v = WW'(i_cfg.tube_radius);
            SRC_R2:   v = WW'(i_cfg.ring_radius);
            SRC_K2:   v = WW'(i_cfg.viewer_distance);
            SRC_K1:   v = WW'(i_cfg.projection_scale);
            SRC_ONE:  v = ONE_Q;
            SRC_OOZ:  v = WW'(ooz);
            SRC_KZH:  v = WW'(r_kz[31:16]);
            SRC_KZL:  v = WW'(r_kz[15:0]);
            SRC_CX:   v = r_cx;
            SRC_CY:   v = r_cy;
            SRC_SASB: v = r_sasb;
            SRC_SACB: v = r_sacb;
            SRC_MX:   v = r_mx;
            SRC_MY:   v = r_my;
            SRC_X:    v = r_x;
            SRC_Y:    v = r_y;
            SRC_T1:   v = r_t1;
            SRC_T2:   v = r_t2;
            default:  v = '0;
        endcase
        return v;
    endfunction

    assign op_a = sel_src(i_cmd.uc.a_sel);
    assign op_b = sel_src(i_cmd.uc.b_sel);

    // truncate toward zero after the fraction shift
    assign q_adj = r_prod + (r_prod < 0 ? Q_BIAS : PW'(0));
    assign q     = WW'(q_adj >>> TRIG_FRAC_BITS);
    assign w_adj = r_wide + (r_wide < 0 ? P_BIAS : XW'(0));
    assign proj_off = CW'(w_adj >>> PROJ_SHIFT);

    tpz_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (DVW'(r_z)),
        .o_busy    (div_busy),
        .o_quot    (div_quot)
    );

    assign ooz = (div_quot > QW'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        if (i_cmd.issue) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.wb) begin
            case (i_cmd.uc.op)
                OP_SETQ, OP_ADDQ, OP_SUBQ: begin
                    case (i_cmd.uc.dst)
                        D_CX:    r_cx   <= (i_cmd.uc.op == OP_SETQ) ? q :
                                           (i_cmd.uc.op == OP_ADDQ) ? r_cx + q : r_cx - q;
                        D_CY:    r_cy   <= q;
                        D_SASB:  r_sasb <= q;
                        D_SACB:  r_sacb <= q;
                        D_MX:    r_mx   <= (i_cmd.uc.op == OP_SETQ) ? q :
                                           (i_cmd.uc.op == OP_ADDQ) ? r_mx + q : r_mx - q;
                        D_MY:    r_my   <= (i_cmd.uc.op == OP_SETQ) ? q :
                                           (i_cmd.uc.op == OP_ADDQ) ? r_my + q : r_my - q;
                        D_X:     r_x    <= (i_cmd.uc.op == OP_SETQ) ? q :
                                           (i_cmd.uc.op == OP_ADDQ) ? r_x + q : r_x - q;
                        D_Y:     r_y    <= (i_cmd.uc.op == OP_SETQ) ? q :
                                           (i_cmd.uc.op == OP_ADDQ) ? r_y + q : r_y - q;
                        D_Z:     r_z    <= (i_cmd.uc.op == OP_SETQ) ? q :
                                           (i_cmd.uc.op == OP_ADDQ) ? r_z + q : r_z - q;
                        D_T1:    r_t1   <= (i_cmd.uc.op == OP_SETQ) ? q :
                                           (i_cmd.uc.op == OP_ADDQ) ? r_t1 + q : r_t1 - q;
                        D_T2:    r_t2   <= q;
                        D_LUM:   r_lum  <= (i_cmd.uc.op == OP_SETQ) ? q :
                                           (i_cmd.uc.op == OP_ADDQ) ? r_lum + q : r_lum - q;
                        default: ;
                    endcase
                end
                OP_KZ:   r_kz   <= r_prod[31:0];
                OP_PHI:  r_wide <= XW'(r_prod) <<< 16;
                OP_PLO:  r_wide <= r_wide + XW'(r_prod);
                OP_FINX: r_xp   <= CW'(SCREEN_WIDTH / 2) + proj_off;
                OP_FINY: r_yp   <= CW'(SCREEN_HEIGHT / 2) - proj_off;
                default: ;
            endcase
        end
        if (i_cmd.lat_cell) begin
            r_cell <= cell_full[CELL_W-1:0];
        end
    end

    assign out_range = (r_xp < 0) || (r_xp >= CW'(SCREEN_WIDTH)) ||
                       (r_yp < 0) || (r_yp >= CW'(SCREEN_HEIGHT));
    assign cell_full = 17'(r_xp[AW-1:0]) + 17'(SCREEN_WIDTH) * 17'(r_yp[AW-1:0]);

    // clear sweep counter wraps back to zero after the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign rd_addr = (r_item.cmd == CMD_READ) ? r_item.read_cell : r_cell;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_depth_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.draw) begin
            r_depth_mem[r_cell] <= ooz;
        end
        r_rd_depth <= r_depth_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_char_mem[r_clr_cnt] <= CHAR_SPACE;
        end else if (i_cmd.draw) begin
            r_char_mem[r_cell] <= new_char;
        end
        r_rd_char <= r_char_mem[rd_addr];
    end

    assign li_raw   = r_lum >>> (TRIG_FRAC_BITS - 3);
    assign li       = (li_raw > WW'(SHADE_MAX)) ? 4'(SHADE_MAX) : li_raw[3:0];
    assign new_char = tpz_shade(li);

    assign out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status     <= i_cmd.out_status;
            r_out.cell_index <= '0;
            r_out.shade_char <= '0;
            if (r_item.cmd == CMD_READ) begin
                r_out.cell_index <= r_item.read_cell;
                r_out.shade_char <= r_rd_char;
            end else if (r_item.cmd == CMD_PLOT) begin
                if (i_cmd.out_status == ST_DONE || i_cmd.out_status == ST_FACE ||
                    i_cmd.out_status == ST_HIDDEN) begin
                    r_out.cell_index <= r_cell;
                end
                if (i_cmd.draw) begin
                    r_out.shade_char <= new_char;
                end
            end
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_out             = r_out;
    assign o_stat.z_nonpos   = (r_z <= 0);
    assign o_stat.off_screen = out_range || (cell_full >= 17'(CELLS));
    assign o_stat.lum_neg    = (r_lum < 0);
    assign o_stat.hidden     = (r_rd_depth > ooz);
    assign o_stat.div_done   = !div_busy;
    assign o_stat.clr_last   = (r_clr_cnt == CELL_W'(CELLS - 1));
    assign o_stat.out_free   = out_free;
    assign o_stat.cmd        = r_item.cmd;

endmodule
`default_nettype wire

[hdl/tpz_ctrl.sv]
// Controller: sequences the multiply microcode, divider, store access and clearing.
// Depends on tpz_pkg and the assertion macro header.
`default_nettype none
`include "torus_point_zbuffer_shader_top_macros.svh"
module tpz_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire tpz_pkg::t_stat i_stat,
    output logic                o_stall,
    output tpz_pkg::t_cmd       o_cmd
);
    import tpz_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_MI, S_MW, S_ZCHK,
        S_DIV, S_RNG, S_RD, S_CMP, S_FIN
    } t_state;

    t_state          r_state;
    logic [PCW-1:0]  r_pc;
    t_status         r_status;
    logic            r_draw;
    logic            r_clr_cmd;

    always_comb begin
        o_cmd            = '0;
        o_cmd.uc         = tpz_ucode(r_pc);
        o_cmd.accept     = (r_state == S_IDLE) && i_valid;
        o_cmd.issue      = (r_state == S_MI);
        o_cmd.wb         = (r_state == S_MW);
        o_cmd.div_start  = (r_state == S_ZCHK) && !i_stat.z_nonpos;
        o_cmd.lat_cell   = (r_state == S_RNG) && !i_stat.off_screen;
        o_cmd.clr_wr     = (r_state == S_CLR);
        o_cmd.out_load   = (r_state == S_FIN) && i_stat.out_free;
        o_cmd.out_status = r_status;
        o_cmd.draw       = (r_state == S_FIN) && i_stat.out_free && r_draw;
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_pc      <= '0;
            r_status  <= ST_DONE;
            r_draw    <= 1'b0;
            r_clr_cmd <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (i_stat.clr_last) begin
                        r_status <= ST_DONE;
                        r_draw   <= 1'b0;
                        r_state  <= r_clr_cmd ? S_FIN : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    case (t_cmd_code'(i_stat.cmd))
                        CMD_PLOT: begin
                            r_pc    <= '0;
                            r_state <= S_MI;
                        end
                        CMD_CLEAR: begin
                            r_clr_cmd <= 1'b1;
                            r_state   <= S_CLR;
                        end
                        default: begin
                            r_status <= ST_DONE;
                            r_draw   <= 1'b0;
                            r_state  <= S_FIN;
                        end
                    endcase
                end
                S_MI: r_state <= S_MW;
                S_MW: begin
                    if (r_pc == PC_Z_LAST) begin
                        r_state <= S_ZCHK;
                    end else if (r_pc == PC_LAST) begin
                        r_state <= S_RNG;
                    end else begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_MI;
                    end
                end
                S_ZCHK: begin
                    if (i_stat.z_nonpos) begin
                        r_status <= ST_ZNEG;
                        r_draw   <= 1'b0;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        r_pc    <= PC_PROJ;
                        r_state <= S_MI;
                    end
                end
                S_RNG: begin
                    if (i_stat.off_screen) begin
                        r_status <= ST_OFF;
                        r_draw   <= 1'b0;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    r_state <= S_FIN;
                    if (i_stat.lum_neg) begin
                        r_status <= ST_FACE;
                        r_draw   <= 1'b0;
                    end else if (i_stat.hidden) begin
                        r_status <= ST_HIDDEN;
                        r_draw   <= 1'b0;
                    end else begin
                        r_status <= ST_DONE;
                        r_draw   <= 1'b1;
                    end
                end
                S_FIN: begin
                    if (i_stat.out_free) begin
                        r_clr_cmd <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TPZ_ASSERT_NEXT(a_div_to_proj, i_clk, i_rst_n, (r_state == S_DIV) && i_stat.div_done, (r_state == S_MI) && (r_pc == PC_PROJ))
    `TPZ_ASSERT(a_no_div_on_zneg, i_clk, i_rst_n, o_cmd.div_start |-> !i_stat.z_nonpos)
    `TPZ_ASSERT(a_draw_is_done, i_clk, i_rst_n, o_cmd.draw |-> (r_status == ST_DONE))
    `TPZ_ASSERT_NEXT(a_fin_waits, i_clk, i_rst_n, (r_state == S_FIN) && !i_stat.out_free, r_state == S_FIN)

endmodule
`default_nettype wire
